// ----- design/twhca_pkg.sv -----
package twhca_pkg;

    typedef enum logic [1:0] {
        KIND_CAP14  = 2'd0,
        KIND_CAP255 = 2'd1,
        KIND_FRZ15  = 2'd2,
        KIND_NOCAP  = 2'd3
    } det_kind_t;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [CFG_IDX_BITS-1:0] REG_KIND = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UFLOW = 2'd2;

    localparam int WIN_BITS = 12;
    localparam int SUM_BITS = 32;
    localparam int ENERGY_BITS = 20;
    localparam int WRAP_UNITS = 4095;
    localparam int CAP_KIND0 = 14;
    localparam int CAP_KIND1 = 255;
    localparam int CAP_KIND2 = 15;

    typedef enum logic [1:0] {
        DIV_IDLE = 2'd0,
        DIV_RUN  = 2'd1,
        DIV_DONE = 2'd2
    } div_state_t;

endpackage

// ----- design/twhca_if.sv -----
interface twhca_in_if #(
    parameter int TIME_BITS = 24
);
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic signed [TIME_BITS-1:0] hit_time;
    logic signed [TIME_BITS-1:0] split_time;
    logic [7:0]                  hit_count;
    logic [7:0]                  inner_tight_in;
    logic [7:0]                  inner_loose_in;
    logic [7:0]                  outer_tight_in;
    logic [7:0]                  outer_loose_in;
    logic [3:0]                  quadrant_bits;
    logic [15:0]                 energy_in;
    logic [7:0]                  channel_number;

    modport source (output valid, req_type, hit_time, split_time, hit_count,
        inner_tight_in, inner_loose_in, outer_tight_in, outer_loose_in,
        quadrant_bits, energy_in, channel_number, input ready);
    modport sink (input valid, req_type, hit_time, split_time, hit_count,
        inner_tight_in, inner_loose_in, outer_tight_in, outer_loose_in,
        quadrant_bits, energy_in, channel_number, output ready);
endinterface

interface twhca_out_if #(
    parameter int TIME_BITS = 24,
    parameter int COUNT_BITS = 10
);
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [COUNT_BITS-1:0]       n_hits;
    logic [COUNT_BITS-1:0]       inner_tight;
    logic [COUNT_BITS-1:0]       inner_loose;
    logic [COUNT_BITS-1:0]       outer_tight;
    logic [COUNT_BITS-1:0]       outer_loose;
    logic [3:0]                  quadrant_mask;
    logic [19:0]                 energy_sum;
    logic signed [TIME_BITS-1:0] average_time;
    logic [7:0]                  channel_out;

    modport source (output valid, accepted, n_hits, inner_tight, inner_loose,
        outer_tight, outer_loose, quadrant_mask, energy_sum, average_time,
        channel_out, input ready);
    modport sink (input valid, accepted, n_hits, inner_tight, inner_loose,
        outer_tight, outer_loose, quadrant_mask, energy_sum, average_time,
        channel_out, output ready);
endinterface

// ----- design/time_window_hit_cluster_accumulator.sv -----
// channel | dir | beat
// in_ch   | in  | one seed or hit request
// out_ch  | out | cluster state and average time
// cfg     | in  | register write, one cycle
// The front end registers the updated cluster state and hands a snapshot
// to a one-entry queue. The back end divides the time sum by the hit count,
// one quotient bit a cycle in the 32-step divider, and takes no new item
// from the queue until its result has moved to the output register.
// Reset clears cluster state and registers to their defaults.
// The front end stalls while the queue entry waits for the divider; the
// divider holds its result while the output register is still full.
module time_window_hit_cluster_accumulator #(
    parameter int TIME_BITS = 24,
    parameter int COUNT_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [twhca_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [twhca_pkg::CFG_DATA_BITS-1:0] cfg_data,
    twhca_in_if.sink                            in_ch,
    twhca_out_if.source                         out_ch
);
    import twhca_pkg::*;

    logic [1:0] kind_reg;
    logic [WIN_BITS-1:0] win_reg;
    logic uf_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_CAP14;
            win_reg <= WIN_BITS'(63);
            uf_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KIND:   kind_reg <= cfg_data[1:0];
                REG_WINDOW: win_reg <= cfg_data[WIN_BITS-1:0];
                REG_UFLOW:  uf_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic q_valid, q_ready, q_accepted;
    logic [COUNT_BITS-1:0] q_n_hits;
    logic [4*COUNT_BITS-1:0] q_types;
    logic [3:0] q_quads;
    logic [ENERGY_BITS-1:0] q_energy;
    logic signed [TIME_BITS-1:0] q_first;
    logic signed [SUM_BITS-1:0] q_sum;
    logic [7:0] q_channel;

    twhca_front #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk, .rst_n, .detector_kind(kind_reg),
        .window(win_reg), .underflow_mode(uf_reg), .in_ch,
        .q_valid, .q_ready, .q_accepted, .q_n_hits, .q_types, .q_quads,
        .q_energy, .q_first, .q_sum, .q_channel);

    twhca_back #(.TIME_BITS(TIME_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_ready, .q_accepted, .q_n_hits, .q_types,
        .q_quads, .q_energy, .q_first, .q_sum, .q_channel, .out_ch);
endmodule

// ----- design/twhca_front.sv -----
module twhca_front #(
    parameter int TIME_BITS = 24,
    parameter int COUNT_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [1:0]                             detector_kind,
    input  logic [twhca_pkg::WIN_BITS-1:0]         window,
    input  logic                                   underflow_mode,
    twhca_in_if.sink                               in_ch,
    // queue entry toward back end
    output logic                                   q_valid,
    input  logic                                   q_ready,
    output logic                                   q_accepted,
    output logic [COUNT_BITS-1:0]                  q_n_hits,
    output logic [4*COUNT_BITS-1:0]                q_types,
    output logic [3:0]                             q_quads,
    output logic [twhca_pkg::ENERGY_BITS-1:0]      q_energy,
    output logic signed [TIME_BITS-1:0]            q_first,
    output logic signed [twhca_pkg::SUM_BITS-1:0]  q_sum,
    output logic [7:0]                             q_channel
);
    import twhca_pkg::*;

    localparam int EB = TIME_BITS + 1;
    localparam int WB = TIME_BITS + 3;
    localparam int PB = TIME_BITS + 10;
    localparam int AW = ((PB > SUM_BITS) ? PB : SUM_BITS) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic signed [WB-1:0] EMAXW = WB'((64'sd1 <<< (EB - 1)) - 1);
    localparam logic signed [WB-1:0] EMINW = WB'(-(64'sd1 <<< (EB - 1)));
    localparam logic signed [AW-1:0] SMAXW = AW'((64'sd1 <<< (SUM_BITS - 1)) - 1);
    localparam logic signed [AW-1:0] SMINW = AW'(-(64'sd1 <<< (SUM_BITS - 1)));

    // cluster state
    logic signed [TIME_BITS-1:0]   first_reg;
    logic signed [EB-1:0]          elow_reg, ehigh_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [COUNT_BITS-1:0]         tot_reg;
    logic [COUNT_BITS-1:0]         tc_reg [4];
    logic [3:0]                    quad_reg;
    logic [ENERGY_BITS-1:0]        en_reg;
    logic [7:0]                    chan_reg;
    logic                          qv_reg, qacc_reg;

    logic signed [WB-1:0] t_w, w_w, hi_w, lo_w, d_w;
    logic [7:0] tin [4];
    logic in_win, skip_all, freeze, take;
    logic signed [TIME_BITS:0] dt;
    logic signed [PB-1:0] prod;
    logic signed [AW-1:0] sum_w;
    logic [COUNT_BITS:0] tot_w;
    logic [COUNT_BITS:0] tc_w [4];
    logic [ENERGY_BITS:0] en_w;

    assign in_ch.ready = !qv_reg || q_ready;
    assign take = in_ch.valid && in_ch.ready;

    assign tin[0] = in_ch.inner_tight_in;
    assign tin[1] = in_ch.inner_loose_in;
    assign tin[2] = in_ch.outer_tight_in;
    assign tin[3] = in_ch.outer_loose_in;

    // window edges for a seed
    always_comb
    begin
        t_w = WB'(in_ch.hit_time);
        w_w = WB'($signed({1'b0, window}));
        hi_w = t_w + w_w;
        d_w = t_w - WB'(in_ch.split_time) - w_w;
        lo_w = t_w - w_w;
        if (underflow_mode && d_w < 0)
            lo_w = t_w + WB'(WRAP_UNITS) + d_w;
        if (hi_w > EMAXW) hi_w = EMAXW;
        if (lo_w < EMINW) lo_w = EMINW;
        if (lo_w > EMAXW) lo_w = EMAXW;
    end

    // hit classification and accumulation
    always_comb
    begin
        in_win = (EB'(in_ch.hit_time) > elow_reg) && (EB'(in_ch.hit_time) < ehigh_reg);
        freeze = (detector_kind == KIND_FRZ15) && (tot_reg == COUNT_BITS'(CAP_KIND2));
        skip_all = ((detector_kind == KIND_CAP14) && (tot_reg == COUNT_BITS'(CAP_KIND0)))
            || ((detector_kind == KIND_CAP255) && (tot_reg == COUNT_BITS'(CAP_KIND1)));
        dt = (TIME_BITS+1)'(in_ch.hit_time) - (TIME_BITS+1)'(first_reg);
        prod = PB'(dt) * $signed({2'b0, in_ch.hit_count});
        sum_w = AW'(sum_reg) + AW'(prod);
        if (sum_w > SMAXW) sum_w = SMAXW;
        if (sum_w < SMINW) sum_w = SMINW;
        tot_w = {1'b0, tot_reg} + (COUNT_BITS+1)'(in_ch.hit_count);
        if (tot_w > {1'b0, CMAX}) tot_w = {1'b0, CMAX};
        for (int i = 0; i < 4; i++)
        begin
            tc_w[i] = {1'b0, tc_reg[i]} + (COUNT_BITS+1)'(tin[i]);
            if (tc_w[i] > {1'b0, CMAX}) tc_w[i] = {1'b0, CMAX};
        end
        en_w = {1'b0, en_reg} + (ENERGY_BITS+1)'(in_ch.energy_in);
        if (en_w[ENERGY_BITS]) en_w = {1'b0, {ENERGY_BITS{1'b1}}};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
            first_reg <= '0;
            elow_reg <= '0;
            ehigh_reg <= '0;
            sum_reg <= '0;
            tot_reg <= '0;
            for (int i = 0; i < 4; i++) tc_reg[i] <= '0;
            quad_reg <= '0;
            en_reg <= '0;
            chan_reg <= '0;
            qacc_reg <= 1'b0;
        end
        else
        begin
            if (take) qv_reg <= 1'b1;
            else if (q_ready) qv_reg <= 1'b0;
            if (take)
            begin
                if (!in_ch.req_type)
                begin
                    qacc_reg <= 1'b1;
                    first_reg <= in_ch.hit_time;
                    chan_reg <= in_ch.channel_number;
                    tot_reg <= COUNT_BITS'(1);
                    sum_reg <= '0;
                    for (int i = 0; i < 4; i++) tc_reg[i] <= COUNT_BITS'(tin[i]);
                    quad_reg <= in_ch.quadrant_bits;
                    en_reg <= ENERGY_BITS'(in_ch.energy_in);
                    ehigh_reg <= EB'(hi_w);
                    elow_reg <= EB'(lo_w);
                end
                else
                begin
                    qacc_reg <= in_win;
                    if (in_win && !skip_all)
                    begin
                        if (!freeze)
                        begin
                            tot_reg <= tot_w[COUNT_BITS-1:0];
                            sum_reg <= sum_w[SUM_BITS-1:0];
                        end
                        for (int i = 0; i < 4; i++) tc_reg[i] <= tc_w[i][COUNT_BITS-1:0];
                        quad_reg <= quad_reg | in_ch.quadrant_bits;
                        en_reg <= en_w[ENERGY_BITS-1:0];
                    end
                end
            end
        end
    end

    assign q_valid = qv_reg;
    assign q_accepted = qacc_reg;
    assign q_n_hits = tot_reg;
    assign q_types = {tc_reg[3], tc_reg[2], tc_reg[1], tc_reg[0]};
    assign q_quads = quad_reg;
    assign q_energy = en_reg;
    assign q_first = first_reg;
    assign q_sum = sum_reg;
    assign q_channel = chan_reg;
endmodule

// ----- design/twhca_back.sv -----
module twhca_back #(
    parameter int TIME_BITS = 24,
    parameter int COUNT_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    output logic                                   q_ready,
    input  logic                                   q_accepted,
    input  logic [COUNT_BITS-1:0]                  q_n_hits,
    input  logic [4*COUNT_BITS-1:0]                q_types,
    input  logic [3:0]                             q_quads,
    input  logic [twhca_pkg::ENERGY_BITS-1:0]      q_energy,
    input  logic signed [TIME_BITS-1:0]            q_first,
    input  logic signed [twhca_pkg::SUM_BITS-1:0]  q_sum,
    input  logic [7:0]                             q_channel,
    twhca_out_if.source                            out_ch
);
    import twhca_pkg::*;

    localparam int SB = SUM_BITS;
    localparam int CW = $clog2(SB + 1);
    localparam int AB = SB + 2;

    div_state_t st_reg, st_next;
    logic [CW-1:0] cnt_reg;
    logic [SB-1:0] quo_reg, rem_reg, mag_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic neg_reg;
    logic acc_reg;
    logic [COUNT_BITS-1:0] nh_reg;
    logic [4*COUNT_BITS-1:0] ty_reg;
    logic [3:0] qd_reg;
    logic [ENERGY_BITS-1:0] en_reg;
    logic signed [TIME_BITS-1:0] first_reg, avg_reg;
    logic [7:0] ch_reg;
    logic ov_reg;
    logic [SB:0] trial;
    logic signed [AB-1:0] avg_w;
    logic load, fin;

    // one quotient bit per cycle
    assign trial = {rem_reg, mag_reg[SB-1]} - (SB+1)'(dvs_reg);

    always_comb
    begin
        st_next = st_reg;
        load = 1'b0;
        fin = 1'b0;
        case (st_reg)
            DIV_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = DIV_RUN;
                    load = 1'b1;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == CW'(SB - 1)) st_next = DIV_DONE;
            end
            DIV_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    st_next = DIV_IDLE;
                    fin = 1'b1;
                end
            end
            default:  st_next = DIV_IDLE;
        endcase
    end
    assign q_ready = load;

    always_comb
    begin
        avg_w = AB'(first_reg) + (neg_reg ? -AB'({1'b0, quo_reg}) : AB'({1'b0, quo_reg}));
        if (avg_w > AB'((64'sd1 <<< (TIME_BITS - 1)) - 1))
            avg_w = AB'((64'sd1 <<< (TIME_BITS - 1)) - 1);
        if (avg_w < AB'(-(64'sd1 <<< (TIME_BITS - 1))))
            avg_w = AB'(-(64'sd1 <<< (TIME_BITS - 1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= DIV_IDLE;
            ov_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_ch.ready) ov_reg <= 1'b0;
            if (fin) ov_reg <= 1'b1;
            if (load) cnt_reg <= '0;
            else if (st_reg == DIV_RUN) cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // divider datapath and result capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= q_accepted;
            nh_reg <= q_n_hits;
            ty_reg <= q_types;
            qd_reg <= q_quads;
            en_reg <= q_energy;
            first_reg <= q_first;
            ch_reg <= q_channel;
            neg_reg <= q_sum[SB-1];
            mag_reg <= q_sum[SB-1] ? (~q_sum + SB'(1)) : q_sum;
            dvs_reg <= q_n_hits;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (st_reg == DIV_RUN)
        begin
            mag_reg <= {mag_reg[SB-2:0], 1'b0};
            if (dvs_reg == '0)
            begin
                quo_reg <= '0;
            end
            else if (!trial[SB])
            begin
                rem_reg <= trial[SB-1:0];
                quo_reg <= {quo_reg[SB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[SB-2:0], mag_reg[SB-1]};
                quo_reg <= {quo_reg[SB-2:0], 1'b0};
            end
        end
        if (fin) avg_reg <= TIME_BITS'(avg_w);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            out_ch.accepted <= acc_reg;
            out_ch.n_hits <= nh_reg;
            out_ch.inner_tight <= ty_reg[COUNT_BITS-1:0];
            out_ch.inner_loose <= ty_reg[2*COUNT_BITS-1:COUNT_BITS];
            out_ch.outer_tight <= ty_reg[3*COUNT_BITS-1:2*COUNT_BITS];
            out_ch.outer_loose <= ty_reg[4*COUNT_BITS-1:3*COUNT_BITS];
            out_ch.quadrant_mask <= qd_reg;
            out_ch.energy_sum <= en_reg;
            out_ch.channel_out <= ch_reg;
        end
    end
    assign out_ch.average_time = avg_reg;
    assign out_ch.valid = ov_reg;
endmodule

// ----- sim/time_window_hit_cluster_accumulator_tb.sv -----
module time_window_hit_cluster_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twhca_pkg::*;

    localparam int TB_TIME_BITS = 24;
    localparam int TB_COUNT_BITS = 10;
    localparam logic REQ_SEED = 1'b0;
    localparam logic REQ_HIT = 1'b1;

    typedef struct {
        logic                           req_type;
        logic signed [TB_TIME_BITS-1:0] hit_time;
        logic signed [TB_TIME_BITS-1:0] split_time;
        logic [7:0]                     hit_count;
        logic [7:0]                     tiles [4];
        logic [3:0]                     quadrant_bits;
        logic [15:0]                    energy_in;
        logic [7:0]                     channel_number;
    } cluster_req_t;

    typedef struct {
        logic                     accepted;
        logic [TB_COUNT_BITS-1:0] n_hits;
        logic [TB_COUNT_BITS-1:0] tiles [4];
        logic [3:0]               quadrant_mask;
        logic [19:0]              energy_sum;
        logic [TB_TIME_BITS-1:0]  average_time;
        logic [7:0]               channel_out;
    } cluster_state_t;

    // expected cluster states and the running cluster they come from
    class cluster_scoreboard;
        int     kind = KIND_CAP14;
        longint win = 63;
        bit     uflow = 0;
        longint first_t, edge_lo, edge_hi, time_acc, hit_total;
        longint tile_total [4];
        logic [3:0] quads_seen = '0;
        longint energy_total;
        logic [7:0] seed_channel = '0;
        cluster_state_t pending_states [$];
        int errors, n_items, n_results, n_hits_in_window;

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint sat_bits(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            return clip(v, -hi - 1, hi);
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_KIND:   kind = val[1:0];
                REG_WINDOW: win = val;
                REG_UFLOW:  uflow = val[0];
                default: ;
            endcase
        endfunction

        function void note_item(cluster_req_t r);
            longint t, sp, nh, avg, d, cmax;
            bit     skip_all, freeze;
            cluster_state_t s;
            cmax = (longint'(1) <<< TB_COUNT_BITS) - 1;
            t = r.hit_time;
            sp = r.split_time;
            nh = r.hit_count;
            s.accepted = 1'b0;
            n_items++;
            if (r.req_type == REQ_SEED) begin
                first_t = t;
                seed_channel = r.channel_number;
                hit_total = 1;
                time_acc = 0;
                for (int i = 0; i < 4; i++) tile_total[i] = r.tiles[i];
                quads_seen = r.quadrant_bits;
                energy_total = r.energy_in;
                edge_hi = sat_bits(t + win, TB_TIME_BITS + 1);
                edge_lo = t - win;
                if (uflow) begin
                    d = t - sp - win;
                    if (d < 0) edge_lo = t + WRAP_UNITS + d;
                end
                edge_lo = sat_bits(edge_lo, TB_TIME_BITS + 1);
                s.accepted = 1'b1;
            end else if (t > edge_lo && t < edge_hi) begin
                s.accepted = 1'b1;
                n_hits_in_window++;
                skip_all = (kind == KIND_CAP14 && hit_total == CAP_KIND0) ||
                           (kind == KIND_CAP255 && hit_total == CAP_KIND1);
                freeze = kind == KIND_FRZ15 && hit_total == CAP_KIND2;
                if (!skip_all) begin
                    if (!freeze) begin
                        hit_total = clip(hit_total + nh, 0, cmax);
                        time_acc = sat_bits(time_acc + (t - first_t) * nh, SUM_BITS);
                    end
                    for (int i = 0; i < 4; i++)
                        tile_total[i] = clip(tile_total[i] + r.tiles[i], 0, cmax);
                    quads_seen |= r.quadrant_bits;
                    energy_total = clip(energy_total + r.energy_in, 0, 1048575);
                end
            end
            avg = hit_total > 0 ? first_t + time_acc / hit_total : first_t;
            avg = sat_bits(avg, TB_TIME_BITS);
            s.n_hits = hit_total[TB_COUNT_BITS-1:0];
            for (int i = 0; i < 4; i++) s.tiles[i] = tile_total[i][TB_COUNT_BITS-1:0];
            s.quadrant_mask = quads_seen;
            s.energy_sum = energy_total[19:0];
            s.average_time = avg[TB_TIME_BITS-1:0];
            s.channel_out = seed_channel;
            pending_states = {pending_states, s};
        endfunction

        function void field_cmp(string name, longint e, longint a);
            if (e != a) begin
                $error("%s mismatch: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(cluster_state_t a);
            cluster_state_t e;
            string tile_names [4];
            tile_names = '{"inner_tight", "inner_loose", "outer_tight", "outer_loose"};
            n_results++;
            if (pending_states.size() == 0) begin
                $error("result beat with no expected cluster state");
                errors++;
                return;
            end
            e = pending_states.pop_front();
            field_cmp("accepted", e.accepted, a.accepted);
            field_cmp("n_hits", e.n_hits, a.n_hits);
            for (int i = 0; i < 4; i++) field_cmp(tile_names[i], e.tiles[i], a.tiles[i]);
            field_cmp("quadrant_mask", e.quadrant_mask, a.quadrant_mask);
            field_cmp("energy_sum", e.energy_sum, a.energy_sum);
            field_cmp("average_time", $signed(e.average_time), $signed(a.average_time));
            field_cmp("channel_out", e.channel_out, a.channel_out);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    twhca_in_if #(.TIME_BITS(TB_TIME_BITS)) in_ch ();
    twhca_out_if #(.TIME_BITS(TB_TIME_BITS), .COUNT_BITS(TB_COUNT_BITS)) out_ch ();

    time_window_hit_cluster_accumulator #(
        .TIME_BITS(TB_TIME_BITS),
        .COUNT_BITS(TB_COUNT_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    cluster_scoreboard sb = new();
    bit no_gaps = 0;
    bit hold_off_req = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("time_window_hit_cluster_accumulator_tb failed");
        $finish;
    end

    // result receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ch.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_off_req = 0;
            end
            out_ch.ready = no_gaps || ($urandom_range(99) >= 36);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        cluster_state_t r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            r.accepted = out_ch.accepted;
            r.n_hits = out_ch.n_hits;
            r.tiles[0] = out_ch.inner_tight;
            r.tiles[1] = out_ch.inner_loose;
            r.tiles[2] = out_ch.outer_tight;
            r.tiles[3] = out_ch.outer_loose;
            r.quadrant_mask = out_ch.quadrant_mask;
            r.energy_sum = out_ch.energy_sum;
            r.average_time = out_ch.average_time;
            r.channel_out = out_ch.channel_out;
            sb.check_result(r);
        end
    end

    function automatic cluster_req_t make_req(logic kind, longint t, longint sp, int nh,
                                              int tile, int q, int e, int ch);
        cluster_req_t r;
        r.req_type = kind;
        r.hit_time = t[TB_TIME_BITS-1:0];
        r.split_time = sp[TB_TIME_BITS-1:0];
        r.hit_count = 8'(nh);
        for (int i = 0; i < 4; i++) r.tiles[i] = 8'(tile);
        r.quadrant_bits = 4'(q);
        r.energy_in = 16'(e);
        r.channel_number = 8'(ch);
        return r;
    endfunction

    function automatic cluster_req_t random_req(logic kind);
        cluster_req_t r;
        r.req_type = kind;
        r.hit_time = TB_TIME_BITS'($urandom());
        r.split_time = TB_TIME_BITS'($urandom());
        r.hit_count = 8'($urandom());
        for (int i = 0; i < 4; i++) r.tiles[i] = 8'($urandom());
        r.quadrant_bits = 4'($urandom());
        r.energy_in = 16'($urandom());
        r.channel_number = 8'($urandom());
        return r;
    endfunction

    // one request beat, entered and left at a falling edge
    task automatic send_req(cluster_req_t r);
        while (!no_gaps && $urandom_range(99) < 36)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.req_type = r.req_type;
        in_ch.hit_time = r.hit_time;
        in_ch.split_time = r.split_time;
        in_ch.hit_count = r.hit_count;
        in_ch.inner_tight_in = r.tiles[0];
        in_ch.inner_loose_in = r.tiles[1];
        in_ch.outer_tight_in = r.tiles[2];
        in_ch.outer_loose_in = r.tiles[3];
        in_ch.quadrant_bits = r.quadrant_bits;
        in_ch.energy_in = r.energy_in;
        in_ch.channel_number = r.channel_number;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(r);
        @(negedge clk);
    endtask

    // wait for the block to drain, then write all three registers
    task automatic set_config(int kind, int win, int uflow);
        in_ch.valid = 1'b0;
        while (sb.pending_states.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_we = 1'b1;
            cfg_index = CFG_IDX_BITS'(i);
            cfg_data = CFG_DATA_BITS'(i == REG_KIND ? kind : (i == REG_WINDOW ? win : uflow));
            sb.set_reg(cfg_index, cfg_data);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // seed followed by hits mostly around the window, some noise
    task automatic cluster_burst(int n_items);
        cluster_req_t r;
        longint t0, w;
        int left;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_req(random_req(1'($urandom_range(1))));
                left--;
                continue;
            end
            r = random_req(REQ_SEED);
            if ($urandom_range(3) == 0)
                r.split_time = TB_TIME_BITS'(longint'(r.hit_time)
                    - longint'($urandom_range(0, int'(2 * sb.win + 10))));
            t0 = longint'(r.hit_time);
            w = sb.win;
            send_req(r);
            left--;
            for (int k = $urandom_range(3, 20); k > 0 && left > 0; k--)
            begin
                r = random_req(REQ_HIT);
                r.hit_time = TB_TIME_BITS'(t0 + longint'($urandom_range(0, int'(2 * w + 4)))
                    - w - 2);
                if ($urandom_range(7) != 0) r.hit_count = 8'($urandom_range(0, 3));
                send_req(r);
                left--;
            end
        end
    endtask

    int cfg_kind [8] = '{KIND_CAP14, KIND_CAP255, KIND_FRZ15, KIND_NOCAP,
                         KIND_FRZ15, KIND_CAP14, KIND_NOCAP, KIND_CAP255};
    int cfg_win [8] = '{4095, 0, 63, 1, 200, 17, 4095, 1000};
    int cfg_uflow [8] = '{1, 0, 1, 0, 1, 1, 0, 1};

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_SEED;
        in_ch.hit_time = '0;
        in_ch.split_time = '0;
        in_ch.hit_count = '0;
        in_ch.inner_tight_in = '0;
        in_ch.inner_loose_in = '0;
        in_ch.outer_tight_in = '0;
        in_ch.outer_loose_in = '0;
        in_ch.quadrant_bits = '0;
        in_ch.energy_in = '0;
        in_ch.channel_number = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: hit before any seed, cap at 14, window edges
        send_req(make_req(REQ_HIT, 0, 0, 5, 1, 1, 1, 1));
        send_req(make_req(REQ_SEED, 1000, 0, 0, 255, 0, 65535, 255));
        send_req(make_req(REQ_HIT, 1062, 0, 13, 255, 15, 65535, 0));
        send_req(make_req(REQ_HIT, 1063, 0, 1, 1, 1, 1, 0));
        send_req(make_req(REQ_HIT, 937, 0, 1, 1, 1, 1, 0));
        send_req(make_req(REQ_HIT, 938, 0, 1, 1, 2, 1, 0));
        send_req(make_req(REQ_SEED, -8388608, 0, 0, 0, 0, 0, 0));
        send_req(make_req(REQ_HIT, -8388607, 0, 255, 255, 15, 65535, 0));
        send_req(make_req(REQ_SEED, 8388607, 0, 0, 0, 8, 0, 128));
        send_req(make_req(REQ_HIT, 8388606, 0, 1, 0, 0, 0, 0));

        // wrap of the low edge near the split time, freeze at 15
        set_config(KIND_FRZ15, 4095, 1);
        send_req(make_req(REQ_SEED, 100, 0, 0, 3, 1, 10, 7));
        send_req(make_req(REQ_HIT, 150, 0, 1, 1, 1, 1, 0));
        send_req(make_req(REQ_HIT, 201, 0, 14, 1, 2, 1, 0));
        send_req(make_req(REQ_HIT, 4000, 0, 3, 1, 4, 1, 0));

        // stop at 255
        set_config(KIND_CAP255, 4095, 0);
        send_req(make_req(REQ_SEED, 0, 0, 0, 0, 0, 0, 3));
        send_req(make_req(REQ_HIT, -4094, 0, 254, 9, 1, 9, 0));
        send_req(make_req(REQ_HIT, 4094, 0, 5, 9, 2, 9, 0));

        // no cap: hit and tile counters saturate
        set_config(KIND_NOCAP, 4095, 0);
        send_req(make_req(REQ_SEED, 5, 0, 0, 255, 0, 65535, 9));
        for (int i = 0; i < 5; i++)
            send_req(make_req(REQ_HIT, -4000, 0, 255, 255, 1 << (i % 4), 65535, 0));

        // random phases over several settings
        for (int p = 0; p < 8; p++)
        begin
            set_config(cfg_kind[p], cfg_win[p], cfg_uflow[p]);
            no_gaps = p == 3;
            if (p == 5) hold_off_req = 1;
            cluster_burst(140);
        end
        no_gaps = 0;
        in_ch.valid = 1'b0;

        while (sb.pending_states.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("covered %0d requests and %0d results, %0d hits inside the window",
                 sb.n_items, sb.n_results, sb.n_hits_in_window);
        $display("over all cap kinds, windows 0 to 4095 and both low edge modes");
        if (sb.errors == 0)
            $display("time_window_hit_cluster_accumulator_tb passed");
        else
            $display("time_window_hit_cluster_accumulator_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/twhca_pkg.sv
design/twhca_if.sv
design/twhca_front.sv
design/twhca_back.sv
design/time_window_hit_cluster_accumulator.sv
sim/time_window_hit_cluster_accumulator_tb.sv
